FILE: sv/fbfl_pkg.sv
package fbfl_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  // link and head codes carry one extra bit so that NUM_BLOCKS is the null code
  localparam int LINK_W     = IDX_W + 1;
  localparam int COUNT_W    = 11;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [LINK_W-1:0]  NULL_LINK  = LINK_W'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] POOL_RESET = COUNT_W'(1024);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   granted_index;
    logic [COUNT_W-1:0] free_blocks;
  } out_item_t;

endpackage

FILE: sv/fixed_block_free_list_allocator.sv
// Alloc, free and unknown requests: the item is registered on accept and served in EXEC,
// where the registered read of the link memory at the list head is ready, once the output
// slot is free; the result is then registered and no new item is taken before that. Reinit:
// result registered the same way, then the link memory is rebuilt one entry per cycle with
// input held off. Synchronous reset loads pool_count 1024 and runs the same rebuild.
module fixed_block_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fbfl_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fbfl_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fbfl_pkg::COUNT_W-1:0] cfg_data
);

  fbfl_pkg::state_t state, state_next;

  logic [fbfl_pkg::COUNT_W-1:0] pool_count;
  logic [fbfl_pkg::LINK_W-1:0]  head, head_next;
  logic [fbfl_pkg::COUNT_W-1:0] count, count_next;
  logic [fbfl_pkg::LINK_W-1:0]  active, active_next;
  logic [fbfl_pkg::LINK_W-1:0]  sweep_cnt, sweep_cnt_next;
  fbfl_pkg::in_item_t           req;

  logic                         ram_we;
  logic [fbfl_pkg::IDX_W-1:0]   ram_waddr;
  logic [fbfl_pkg::LINK_W-1:0]  ram_wdata;
  logic [fbfl_pkg::LINK_W-1:0]  ram_rdata;

  logic                         slot_free;
  logic                         load_out;
  fbfl_pkg::out_item_t          out_item_next;
  logic [fbfl_pkg::LINK_W-1:0]  sweep_succ;
  logic [fbfl_pkg::LINK_W-1:0]  pool_active;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == fbfl_pkg::ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign sweep_succ  = sweep_cnt + fbfl_pkg::LINK_W'(1);
  assign pool_active = (32'(pool_count) > 32'(fbfl_pkg::NUM_BLOCKS)) ?
                       fbfl_pkg::NULL_LINK : fbfl_pkg::LINK_W'(pool_count);

  // read port always follows the head; it is stable while an item waits in EXEC
  fbfl_ram #(
    .WIDTH(fbfl_pkg::LINK_W),
    .DEPTH(fbfl_pkg::NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[fbfl_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbfl_pkg::ST_SWEEP;
      pool_count <= fbfl_pkg::POOL_RESET;
      head       <= '0;
      count      <= fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS);
      active     <= fbfl_pkg::NULL_LINK;
      sweep_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      active    <= active_next;
      sweep_cnt <= sweep_cnt_next;
      if (cfg_valid) begin
        pool_count <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_item;
    end
    if (load_out) begin
      out_item <= out_item_next;
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    active_next    = active;
    sweep_cnt_next = sweep_cnt;
    ram_we         = 1'b0;
    ram_waddr      = req.block_index;
    ram_wdata      = head;
    load_out       = 1'b0;
    out_item_next.status        = fbfl_pkg::STAT_OK;
    out_item_next.granted_index = '0;
    out_item_next.free_blocks   = count;

    unique case (state)
      fbfl_pkg::ST_SWEEP: begin
        if (sweep_cnt == active) begin
          state_next = fbfl_pkg::ST_IDLE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = sweep_cnt[fbfl_pkg::IDX_W-1:0];
          ram_wdata      = (sweep_succ < active) ? sweep_succ : fbfl_pkg::NULL_LINK;
          sweep_cnt_next = sweep_succ;
        end
      end

      fbfl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = fbfl_pkg::ST_EXEC;
        end
      end

      fbfl_pkg::ST_EXEC: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = fbfl_pkg::ST_IDLE;
          unique case (req.req_type)
            fbfl_pkg::REQ_ALLOC: begin
              if (head == fbfl_pkg::NULL_LINK) begin
                out_item_next.status = fbfl_pkg::STAT_EMPTY;
              end else begin
                out_item_next.granted_index = head[fbfl_pkg::IDX_W-1:0];
                head_next  = ram_rdata;
                count_next = (count != '0) ? count - fbfl_pkg::COUNT_W'(1) : count;
              end
            end
            fbfl_pkg::REQ_FREE: begin
              if ({1'b0, req.block_index} < active) begin
                ram_we     = 1'b1;
                head_next  = {1'b0, req.block_index};
                count_next = (count != fbfl_pkg::COUNT_MAX) ?
                             count + fbfl_pkg::COUNT_W'(1) : count;
              end else begin
                out_item_next.status = fbfl_pkg::STAT_BAD;
              end
            end
            fbfl_pkg::REQ_REINIT: begin
              active_next    = pool_active;
              head_next      = (pool_active != '0) ? '0 : fbfl_pkg::NULL_LINK;
              count_next     = fbfl_pkg::COUNT_W'(pool_active);
              sweep_cnt_next = '0;
              state_next     = fbfl_pkg::ST_SWEEP;
            end
            fbfl_pkg::REQ_NONE: begin
            end
            default: begin
            end
          endcase
          out_item_next.free_blocks = count_next;
        end
      end

      default: begin
        state_next = fbfl_pkg::ST_IDLE;
      end
    endcase
  end

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // with the output slot free at accept, EXEC loads the result without a stall
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!out_valid || out_ready) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // a granted block is always inside the active pool
  a_grant_in_pool: assert property (@(posedge clk) disable iff (rst)
    load_out && req.req_type == fbfl_pkg::REQ_ALLOC && head != fbfl_pkg::NULL_LINK
      |-> head < active)
    else $error("list head outside the active pool");

endmodule

FILE: sv/fbfl_ram.sv
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/fbfl_pool_checker.sv
module fbfl_pool_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  fbfl_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  fbfl_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [fbfl_pkg::COUNT_W-1:0] cfg_data,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [fbfl_pkg::LINK_W-1:0]  blk_link [fbfl_pkg::NUM_BLOCKS];
  logic [fbfl_pkg::LINK_W-1:0]  blk_head;
  logic [fbfl_pkg::COUNT_W-1:0] blk_free_cnt;
  logic [fbfl_pkg::COUNT_W-1:0] blk_active;
  logic [fbfl_pkg::COUNT_W-1:0] pool_size_reg;
  fbfl_pkg::out_item_t          awaited_replies [$];
  fbfl_pkg::out_item_t          want;

  // ascending chain 0 -> 1 -> ... -> active-1 -> null
  function automatic void rebuild_free_list();
    int i;
    blk_active = (pool_size_reg > fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS)) ?
                 fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS) : pool_size_reg;
    for (i = 0; i < fbfl_pkg::NUM_BLOCKS; i++)
      blk_link[i] = (i + 1 < int'(blk_active)) ? fbfl_pkg::LINK_W'(i + 1) : fbfl_pkg::NULL_LINK;
    blk_head     = (blk_active != '0) ? '0 : fbfl_pkg::NULL_LINK;
    blk_free_cnt = blk_active;
  endfunction

  function automatic fbfl_pkg::out_item_t serve_request(input fbfl_pkg::in_item_t req);
    fbfl_pkg::out_item_t r;
    r = '0;
    r.status = fbfl_pkg::STAT_OK;
    case (req.req_type)
      fbfl_pkg::REQ_ALLOC: begin
        if (blk_head < fbfl_pkg::LINK_W'(fbfl_pkg::NUM_BLOCKS)) begin
          r.granted_index = blk_head[fbfl_pkg::IDX_W-1:0];
          blk_head = blk_link[blk_head[fbfl_pkg::IDX_W-1:0]];
          if (blk_free_cnt != '0) blk_free_cnt = blk_free_cnt - fbfl_pkg::COUNT_W'(1);
        end else begin
          r.status = fbfl_pkg::STAT_EMPTY;
        end
      end
      fbfl_pkg::REQ_FREE: begin
        // double frees are pushed again on purpose
        if (fbfl_pkg::COUNT_W'(req.block_index) < blk_active) begin
          blk_link[req.block_index] = blk_head;
          blk_head = fbfl_pkg::LINK_W'(req.block_index);
          if (blk_free_cnt != fbfl_pkg::COUNT_MAX)
            blk_free_cnt = blk_free_cnt + fbfl_pkg::COUNT_W'(1);
        end else begin
          r.status = fbfl_pkg::STAT_BAD;
        end
      end
      fbfl_pkg::REQ_REINIT: begin
        rebuild_free_list();
      end
      default: begin
      end
    endcase
    r.free_blocks = blk_free_cnt;
    return r;
  endfunction

  function automatic void compare_field(input string fname, input int exp_v, input int act_v,
                                        input logic has_x);
    if (has_x || exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", fname, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      pool_size_reg = fbfl_pkg::POOL_RESET;
      rebuild_free_list();
      awaited_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) pool_size_reg = cfg_data;
      if (in_valid && in_ready) awaited_replies.push_back(serve_request(in_item));
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result with none outstanding: status %0d granted_index %0d free_blocks %0d",
                 out_item.status, out_item.granted_index, out_item.free_blocks);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status", int'(want.status), int'(out_item.status),
                        $isunknown(out_item.status));
          compare_field("granted_index", int'(want.granted_index),
                        int'(out_item.granted_index), $isunknown(out_item.granted_index));
          compare_field("free_blocks", int'(want.free_blocks), int'(out_item.free_blocks),
                        $isunknown(out_item.free_blocks));
        end
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

FILE: sim/tb_fixed_block_free_list_allocator.sv
module tb_fixed_block_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  fbfl_pkg::in_item_t           in_item   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  fbfl_pkg::out_item_t          out_item;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [fbfl_pkg::COUNT_W-1:0] cfg_data  = '0;

  int                           checker_errors;
  int                           pending;
  bit                           no_idle   = 1'b0;
  int                           stall_left = 0;

  // items in flight, and blocks the pool has handed out to us
  fbfl_pkg::in_item_t           issued_items [$];
  logic [fbfl_pkg::IDX_W-1:0]   held_blocks [$];
  fbfl_pkg::in_item_t           done_item;
  int                           hit;

  always #4 clk = ~clk;

  fixed_block_free_list_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fbfl_pool_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (checker_errors),
    .pending   (pending)
  );

  // mostly short, now and then long
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      issued_items.delete();
      held_blocks.delete();
    end else begin
      if (in_valid && in_ready) issued_items.push_back(in_item);
      if (out_valid && out_ready && issued_items.size() > 0) begin
        done_item = issued_items.pop_front();
        if (done_item.req_type == fbfl_pkg::REQ_ALLOC && out_item.status == fbfl_pkg::STAT_OK) begin
          held_blocks.push_back(out_item.granted_index);
        end else if (done_item.req_type == fbfl_pkg::REQ_FREE &&
                     out_item.status == fbfl_pkg::STAT_OK) begin
          hit = -1;
          for (int j = 0; j < held_blocks.size(); j++)
            if (hit < 0 && held_blocks[j] == done_item.block_index) hit = j;
          if (hit >= 0) held_blocks.delete(hit);
        end else if (done_item.req_type == fbfl_pkg::REQ_REINIT) begin
          held_blocks.delete();
        end
      end
    end
  end

  task automatic issue(input logic [fbfl_pkg::REQ_W-1:0] kind,
                       input logic [fbfl_pkg::IDX_W-1:0] idx);
    fbfl_pkg::in_item_t nxt;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    nxt.req_type    = kind;
    nxt.block_index = idx;
    in_valid <= 1'b1;
    in_item  <= nxt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // all results back and the rebuild sweep over
  task automatic wait_pool_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic set_pool_count(input logic [fbfl_pkg::COUNT_W-1:0] value);
    wait_pool_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                           sent_cnt;
    int                           n;
    int                           r;
    int                           s;
    int                           k;
    int                           span;
    logic [fbfl_pkg::COUNT_W-1:0] pool_pick;
    logic [fbfl_pkg::IDX_W-1:0]   idx;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset pool: 1024 blocks
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_ALLOC, '1);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_FREE, fbfl_pkg::IDX_W'(1));
    issue(fbfl_pkg::REQ_FREE, '1);
    issue(fbfl_pkg::REQ_FREE, '0);
    issue(fbfl_pkg::REQ_NONE, '1);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_REINIT, '0);

    // empty pool
    set_pool_count('0);
    issue(fbfl_pkg::REQ_REINIT, '1);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_FREE, '0);
    issue(fbfl_pkg::REQ_FREE, '1);
    issue(fbfl_pkg::REQ_NONE, '0);

    // oversized count clamps to NUM_BLOCKS
    set_pool_count('1);
    issue(fbfl_pkg::REQ_REINIT, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_FREE, '1);
    issue(fbfl_pkg::REQ_FREE, '0);

    // single block, double free
    set_pool_count(fbfl_pkg::COUNT_W'(1));
    issue(fbfl_pkg::REQ_REINIT, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_FREE, fbfl_pkg::IDX_W'(1));
    issue(fbfl_pkg::REQ_FREE, '0);
    issue(fbfl_pkg::REQ_FREE, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);

    // block 0 linked to itself: allocs keep granting while the counter pins at zero
    issue(fbfl_pkg::REQ_REINIT, '0);
    issue(fbfl_pkg::REQ_FREE, '0);
    repeat (4) issue(fbfl_pkg::REQ_ALLOC, fbfl_pkg::IDX_W'($urandom));

    sent_cnt = 0;
    while (sent_cnt < 180) begin
      case ($urandom_range(0, 9))
        0:       pool_pick = '0;
        1:       pool_pick = fbfl_pkg::COUNT_W'(1);
        2:       pool_pick = fbfl_pkg::COUNT_W'(2);
        3, 4, 5: pool_pick = fbfl_pkg::COUNT_W'($urandom_range(3, 16));
        6:       pool_pick = fbfl_pkg::COUNT_W'($urandom_range(17, 200));
        7:       pool_pick = fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS);
        8:       pool_pick = fbfl_pkg::COUNT_W'($urandom_range(fbfl_pkg::NUM_BLOCKS + 1, 2047));
        default: pool_pick = fbfl_pkg::COUNT_W'($urandom_range(0, 2047));
      endcase
      set_pool_count(pool_pick);
      no_idle = ($urandom_range(0, 3) == 0);
      // sometimes the new count waits for a later reinit
      if ($urandom_range(0, 4) != 0) issue(fbfl_pkg::REQ_REINIT, fbfl_pkg::IDX_W'($urandom));
      span = (pool_pick > fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS)) ?
             fbfl_pkg::NUM_BLOCKS : int'(pool_pick);
      n = $urandom_range(20, 60);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          issue(fbfl_pkg::REQ_REINIT, fbfl_pkg::IDX_W'($urandom));
        end else if (r < 5) begin
          issue(fbfl_pkg::REQ_NONE, fbfl_pkg::IDX_W'($urandom));
        end else if (r < 52) begin
          issue(fbfl_pkg::REQ_ALLOC, fbfl_pkg::IDX_W'($urandom));
        end else begin
          s = $urandom_range(0, 9);
          if (s < 7 && held_blocks.size() > 0) begin
            r = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[r];
          end else if (s < 9) begin
            idx = (span == 0) ? '0 : fbfl_pkg::IDX_W'($urandom_range(0, span - 1));
          end else begin
            idx = fbfl_pkg::IDX_W'($urandom);
          end
          issue(fbfl_pkg::REQ_FREE, idx);
        end
        sent_cnt++;
      end
    end

    // top index of a full pool is pushed and handed out again
    set_pool_count(fbfl_pkg::COUNT_W'(fbfl_pkg::NUM_BLOCKS));
    no_idle = ($urandom_range(0, 1) == 0);
    issue(fbfl_pkg::REQ_REINIT, '0);
    issue(fbfl_pkg::REQ_FREE, '1);
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_FREE, fbfl_pkg::IDX_W'(fbfl_pkg::NUM_BLOCKS / 2));
    issue(fbfl_pkg::REQ_ALLOC, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);

    // repeated frees on a full pool push the counter to its ceiling
    no_idle = 1'b1;
    issue(fbfl_pkg::REQ_REINIT, '0);
    repeat (int'(fbfl_pkg::COUNT_MAX) - fbfl_pkg::NUM_BLOCKS + 8)
      issue(fbfl_pkg::REQ_FREE, '0);
    no_idle = 1'b0;
    repeat (4) issue(fbfl_pkg::REQ_ALLOC, fbfl_pkg::IDX_W'($urandom));
    issue(fbfl_pkg::REQ_REINIT, '0);
    issue(fbfl_pkg::REQ_ALLOC, '0);

    wait_pool_idle();
    repeat (20) @(posedge clk);
    if (checker_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
